// ===== rtl/core/crtb_pkg.sv =====
// Shared types and opcode/kind codes for the CFI row table builder.
`default_nettype none
package crtb_pkg;

    typedef enum logic [4:0] {
        OP_START_FDE  = 5'd0,
        OP_AUG_S      = 5'd1,
        OP_AFTER_CIE  = 5'd2,
        OP_SET_LOC    = 5'd3,
        OP_DEF_CFA    = 5'd4,
        OP_CFA_REG    = 5'd5,
        OP_CFA_OFF    = 5'd6,
        OP_CFA_EXPR   = 5'd7,
        OP_OFFSET     = 5'd8,
        OP_REGISTER   = 5'd9,
        OP_RESTORE    = 5'd10,
        OP_SAME       = 5'd11,
        OP_UNDEF      = 5'd12,
        OP_VAL_OFF    = 5'd13,
        OP_EXPR       = 5'd14,
        OP_VAL_EXPR   = 5'd15,
        OP_REMEMBER   = 5'd16,
        OP_RESTORE_ST = 5'd17
    } opcode_t;

    localparam logic [1:0] KIND_CFA   = 2'd0;
    localparam logic [1:0] KIND_REG   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;
    localparam logic [1:0] KIND_FDE   = 2'd3;

    localparam logic [2:0] RULE_UNSET    = 3'd0;
    localparam logic [2:0] RULE_UNDEF    = 3'd1;
    localparam logic [2:0] RULE_SAME     = 3'd2;
    localparam logic [2:0] RULE_AT_OFF   = 3'd3;
    localparam logic [2:0] RULE_VAL_OFF  = 3'd4;
    localparam logic [2:0] RULE_IN_REG   = 3'd5;
    localparam logic [2:0] RULE_EXPR     = 3'd6;
    localparam logic [2:0] RULE_VAL_EXPR = 3'd7;

    localparam logic [1:0] CFA_UNDEF   = 2'd0;
    localparam logic [1:0] CFA_REG_OFF = 2'd1;
    localparam logic [1:0] CFA_EXPR    = 2'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_DEEP  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    // One rule entry: kind, register, offset.
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  rreg;
        logic [63:0] off;
    } rule_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  rreg;
        logic [63:0] off;
    } cfa_t;

    // Controller -> datapath commands.
    typedef struct packed {
        logic load_in;     // capture input transaction
        logic exec;        // apply the opcode update
        logic clear;       // start_fde clear
        logic clear_cie;   // clear cie entry at idx
        logic cie_copy;    // copy cur[idx] to cie[idx]
        logic push_wr;     // write cur[idx] to stack
        logic push_cfa;    // write cfa to stack
        logic pop_rd;      // issue stack read for idx
        logic pop_wr;      // take stack read data into cur
        logic pop_cfa;     // take cfa stack data
        logic cnt_inc;
        logic cnt_dec;
        logic emit_cfa;    // load output register with cfa item
        logic emit_reg;    // load output register with reg item
        logic emit_err;
        logic emit_fde;
        logic set_pc;      // commit new open row pc
        logic [1:0] err;
        logic [5:0] idx;
        logic last;
    } crtb_cmd_t;

    typedef struct packed {
        logic [4:0] op;
        logic       row_due;
        logic       stack_full;
        logic       stack_empty;
        logic       out_busy;
    } crtb_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/crtb_ctrl.sv =====
// Controller state machine sequencing copies, stack moves and row emission.
`default_nettype none
module crtb_ctrl
    import crtb_pkg::*;
#(
    parameter int NUM_REGS = 17
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  crtb_stat_t      stat,
    output crtb_cmd_t       cmd
);
    localparam logic [5:0] LAST_IDX = 6'(NUM_REGS - 1);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DEC    = 7'b0000010,
        ST_CLEAR  = 7'b0000100,
        ST_COPY   = 7'b0001000,
        ST_PUSH   = 7'b0010000,
        ST_POP    = 7'b0100000,
        ST_ROW    = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] idx_reg, idx_next;
    logic       rd_pend_reg, rd_pend_next;  // pop read in flight
    logic       cfa_done_reg, cfa_done_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        rd_pend_next  = 1'b0;
        cfa_done_next = cfa_done_reg;
        cmd           = '0;
        cmd.idx       = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                // start every sweep, and the first pop read, at entry zero
                idx_next = '0;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DEC;
                end
            end
            ST_DEC: begin
                idx_next      = '0;
                cfa_done_next = 1'b0;
                unique case (stat.op)
                    OP_START_FDE: begin
                        if (!stat.out_busy) begin
                            cmd.clear    = 1'b1;
                            cmd.emit_fde = 1'b1;
                            cmd.last     = 1'b1;
                            state_next   = ST_CLEAR;
                        end
                    end
                    OP_AFTER_CIE: state_next = ST_COPY;
                    OP_SET_LOC: begin
                        if (!stat.row_due) begin
                            cmd.set_pc = 1'b1;
                            state_next = ST_IDLE;
                        end else begin
                            state_next = ST_ROW;
                        end
                    end
                    OP_REMEMBER: begin
                        if (stat.stack_full) begin
                            if (!stat.out_busy) begin
                                cmd.emit_err = 1'b1;
                                cmd.err      = ERR_DEEP;
                                cmd.last     = 1'b1;
                                state_next   = ST_IDLE;
                            end
                        end else begin
                            cmd.push_cfa = 1'b1;
                            state_next   = ST_PUSH;
                        end
                    end
                    OP_RESTORE_ST: begin
                        if (stat.stack_empty) begin
                            if (!stat.out_busy) begin
                                cmd.emit_err = 1'b1;
                                cmd.err      = ERR_EMPTY;
                                cmd.last     = 1'b1;
                                state_next   = ST_IDLE;
                            end
                        end else begin
                            cmd.pop_rd   = 1'b1;
                            rd_pend_next = 1'b1;
                            state_next   = ST_POP;
                        end
                    end
                    default: begin
                        cmd.exec   = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_CLEAR: begin
                cmd.clear_cie = 1'b1;
                idx_next      = idx_reg + 6'd1;
                if (idx_reg == LAST_IDX) state_next = ST_IDLE;
            end
            ST_COPY: begin
                cmd.cie_copy = 1'b1;
                idx_next     = idx_reg + 6'd1;
                if (idx_reg == LAST_IDX) state_next = ST_IDLE;
            end
            ST_PUSH: begin
                cmd.push_wr = 1'b1;
                idx_next    = idx_reg + 6'd1;
                if (idx_reg == LAST_IDX) begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_POP: begin
                // read data for idx_reg arrives in the cycle after its address
                cmd.pop_wr  = 1'b1;
                cmd.pop_cfa = (idx_reg == '0);
                if (idx_reg == LAST_IDX) begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = ST_IDLE;
                end else begin
                    idx_next     = idx_reg + 6'd1;
                    cmd.pop_rd   = 1'b1;
                    cmd.idx      = idx_reg + 6'd1;
                    rd_pend_next = 1'b1;
                end
            end
            ST_ROW: begin
                if (!stat.out_busy) begin
                    if (!cfa_done_reg) begin
                        cmd.emit_cfa  = 1'b1;
                        cfa_done_next = 1'b1;
                    end else begin
                        cmd.emit_reg = 1'b1;
                        idx_next     = idx_reg + 6'd1;
                        if (idx_reg == LAST_IDX) begin
                            cmd.last   = 1'b1;
                            cmd.set_pc = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            rd_pend_reg  <= 1'b0;
            cfa_done_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            rd_pend_reg  <= rd_pend_next;
            cfa_done_reg <= cfa_done_next;
        end
    end

    a_pop_has_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POP) |-> rd_pend_reg)
        else $error("pop step without a pending stack read");
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (idx_reg <= LAST_IDX))
        else $error("rule index out of range");
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_in |=> (state_reg == ST_DEC))
        else $error("accepted transaction not decoded");
endmodule
`default_nettype wire

// ===== rtl/core/crtb_dp.sv =====
// Datapath: rule tables, remember stack memory, CFA state and output register.
`default_nettype none
module crtb_dp
    import crtb_pkg::*;
#(
    parameter int NUM_REGS    = 17,
    parameter int STACK_DEPTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [63:0] cfg_load_bias,
    input  wire logic [4:0]  in_opcode,
    input  wire logic [15:0] in_reg_number,
    input  wire logic [63:0] in_value,
    input  wire logic [63:0] in_value_two,
    input  crtb_cmd_t        cmd,
    output crtb_stat_t       stat,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [223:0]     m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);
    localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int MW = $clog2(STACK_DEPTH * NUM_REGS);
    localparam int MD = STACK_DEPTH * NUM_REGS;

    // captured transaction
    logic [4:0]  op_reg;
    logic [15:0] rnum_reg;
    logic [63:0] val_reg, val2_reg;

    logic [63:0] open_pc_reg;
    logic        sig_reg, exo_reg;
    cfa_t        cfa_reg;
    rule_t       cur_reg [NUM_REGS];
    rule_t       cie_reg [NUM_REGS];
    logic [CW-1:0] cnt_reg;

    rule_t       stk_mem [MD];
    cfa_t        cfa_mem [STACK_DEPTH];
    rule_t       stk_rd_reg;
    cfa_t        cfa_rd_reg;

    logic [RW-1:0] ridx;
    logic [RW-1:0] tgt;
    logic          tgt_ok;
    logic [63:0]   pc_biased;
    logic [SW-1:0] top, slot;
    logic [MW-1:0] base_top, base_slot;

    assign ridx      = cmd.idx[RW-1:0];
    assign tgt_ok    = ({16'd0, rnum_reg} < 32'(NUM_REGS));
    assign tgt       = rnum_reg[RW-1:0];
    assign pc_biased = val_reg - cfg_load_bias;
    assign slot      = cnt_reg[SW-1:0];
    assign top       = SW'(cnt_reg - CW'(1));
    assign base_slot = MW'(32'(slot) * NUM_REGS + 32'(ridx));
    assign base_top  = MW'(32'(top) * NUM_REGS + 32'(ridx));

    assign stat.op          = op_reg;
    assign stat.row_due     = pc_biased > open_pc_reg;
    assign stat.stack_full  = cnt_reg >= CW'(STACK_DEPTH);
    assign stat.stack_empty = cnt_reg == '0;
    assign stat.out_busy    = m_tvalid && !m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg   <= in_opcode;
            rnum_reg <= in_reg_number;
            val_reg  <= in_value;
            val2_reg <= in_value_two;
        end
    end

    // remember stack memories
    always_ff @(posedge aclk) begin
        if (cmd.push_wr) stk_mem[base_slot] <= cur_reg[ridx];
        if (cmd.push_cfa) cfa_mem[slot] <= cfa_reg;
        if (cmd.pop_rd) begin
            stk_rd_reg <= stk_mem[base_top];
            cfa_rd_reg <= cfa_mem[top];
        end
    end

    logic [RW-1:0] pop_idx_reg;
    always_ff @(posedge aclk) begin
        if (cmd.pop_rd) pop_idx_reg <= ridx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_pc_reg <= '0;
            sig_reg     <= 1'b0;
            exo_reg     <= 1'b0;
            cfa_reg     <= '0;
            cnt_reg     <= '0;
            for (int i = 0; i < NUM_REGS; i++) begin
                cur_reg[i] <= '0;
                cie_reg[i] <= '0;
            end
        end else begin
            if (cmd.clear) begin
                sig_reg     <= 1'b0;
                exo_reg     <= 1'b0;
                cfa_reg     <= '0;
                cnt_reg     <= '0;
                open_pc_reg <= pc_biased;
                for (int i = 0; i < NUM_REGS; i++) cur_reg[i] <= '0;
            end
            if (cmd.clear_cie) cie_reg[ridx] <= '0;
            if (cmd.cie_copy) cie_reg[ridx] <= cur_reg[ridx];
            if (cmd.set_pc) open_pc_reg <= pc_biased;
            if (cmd.cnt_inc) cnt_reg <= cnt_reg + CW'(1);
            if (cmd.cnt_dec) cnt_reg <= cnt_reg - CW'(1);
            if (cmd.pop_wr) cur_reg[pop_idx_reg] <= stk_rd_reg;
            if (cmd.pop_cfa) cfa_reg <= cfa_rd_reg;
            if (cmd.exec) begin
                unique case (op_reg) inside
                    OP_AUG_S: sig_reg <= 1'b1;
                    OP_DEF_CFA: cfa_reg <= '{CFA_REG_OFF, rnum_reg[7:0], val_reg};
                    OP_CFA_REG: begin
                        cfa_reg.kind <= CFA_REG_OFF;
                        cfa_reg.rreg <= val_reg[7:0];
                    end
                    OP_CFA_OFF: begin
                        cfa_reg.kind <= CFA_REG_OFF;
                        cfa_reg.off  <= val_reg;
                    end
                    OP_CFA_EXPR: cfa_reg <= '{CFA_EXPR, 8'd0, 64'd0};
                    OP_OFFSET, OP_REGISTER, OP_RESTORE, OP_SAME, OP_UNDEF,
                    OP_VAL_OFF, OP_EXPR, OP_VAL_EXPR: begin
                        if (!tgt_ok) begin
                            exo_reg <= 1'b1;
                        end else begin
                            case (op_reg)
                                OP_OFFSET:   cur_reg[tgt] <= '{RULE_AT_OFF, 8'd0, val_reg};
                                OP_REGISTER: cur_reg[tgt] <= '{RULE_IN_REG, val_reg[7:0], 64'd0};
                                OP_RESTORE:  cur_reg[tgt] <= cie_reg[tgt];
                                OP_SAME:     cur_reg[tgt] <= '{RULE_SAME, 8'd0, 64'd0};
                                OP_UNDEF:    cur_reg[tgt] <= '{RULE_UNDEF, 8'd0, 64'd0};
                                OP_VAL_OFF:  cur_reg[tgt] <= '{RULE_VAL_OFF, 8'd0, val_reg};
                                OP_EXPR:     cur_reg[tgt] <= '{RULE_EXPR, 8'd0, 64'd0};
                                default:     cur_reg[tgt] <= '{RULE_VAL_EXPR, 8'd0, 64'd0};
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // output register: tdata fields row_pc_start, row_reg_index, rule_kind, rule_reg,
    // rule_offset, error_code, sig_frame, exotic, fde_pc_end, return_register;
    // tuser item_kind
    logic [63:0] out_pc_reg, out_off_reg, out_end_reg;
    logic [63:0] out_pc_next, out_off_next, out_end_next;
    logic [5:0]  out_idx_reg, out_idx_next;
    logic [2:0]  out_kind_reg, out_kind_next;
    logic [7:0]  out_rreg_reg, out_rreg_next, out_ret_reg, out_ret_next;
    logic [1:0]  out_err_reg, out_err_next, out_ik_reg, out_ik_next;
    logic        out_sig_reg, out_sig_next, out_exo_reg, out_exo_next;
    logic        emit;

    assign emit = cmd.emit_cfa | cmd.emit_reg | cmd.emit_err | cmd.emit_fde;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (emit) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_comb begin
        out_ik_next   = KIND_FDE;
        out_pc_next   = '0;
        out_off_next  = '0;
        out_end_next  = '0;
        out_idx_next  = '0;
        out_kind_next = '0;
        out_rreg_next = '0;
        out_ret_next  = '0;
        out_err_next  = ERR_NONE;
        out_sig_next  = sig_reg;
        out_exo_next  = exo_reg;
        if (cmd.emit_cfa) begin
            out_ik_next   = KIND_CFA;
            out_pc_next   = open_pc_reg;
            out_kind_next = {1'b0, cfa_reg.kind};
            out_rreg_next = cfa_reg.rreg;
            out_off_next  = cfa_reg.off;
        end else if (cmd.emit_reg) begin
            out_ik_next   = KIND_REG;
            out_pc_next   = open_pc_reg;
            out_idx_next  = cmd.idx;
            out_kind_next = cur_reg[ridx].kind;
            out_rreg_next = cur_reg[ridx].rreg;
            out_off_next  = cur_reg[ridx].off;
        end else if (cmd.emit_err) begin
            out_ik_next  = KIND_ERROR;
            out_err_next = cmd.err;
        end else begin
            // start_fde: flags cleared, bounds from this transaction
            out_sig_next = 1'b0;
            out_exo_next = 1'b0;
            out_pc_next  = pc_biased;
            out_end_next = val2_reg - cfg_load_bias;
            out_ret_next = rnum_reg[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_ik_reg   <= out_ik_next;
            out_pc_reg   <= out_pc_next;
            out_off_reg  <= out_off_next;
            out_end_reg  <= out_end_next;
            out_idx_reg  <= out_idx_next;
            out_kind_reg <= out_kind_next;
            out_rreg_reg <= out_rreg_next;
            out_ret_reg  <= out_ret_next;
            out_err_reg  <= out_err_next;
            out_sig_reg  <= out_sig_next;
            out_exo_reg  <= out_exo_next;
            m_tlast      <= cmd.last;
        end
    end

    assign m_tdata = {3'd0, out_ret_reg, out_end_reg, out_exo_reg, out_sig_reg, out_err_reg,
                      out_off_reg, out_rreg_reg, out_kind_reg, out_idx_reg, out_pc_reg};
    assign m_tuser = out_ik_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !emit)
        else $error("output register overwritten while stalled");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(STACK_DEPTH))
        else $error("stack count past depth");
    a_no_inc_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_inc |-> !stat.stack_full)
        else $error("push onto full stack");
endmodule
`default_nettype wire

// ===== rtl/core/cfi_row_table_builder.sv =====
// Top level of the CFI row table builder.
//
// Input stream s_*: one decoded CFI opcode per transaction. tuser holds
// opcode[4:0]; tdata holds, from bit 0: reg_number[15:0], value[63:0],
// value_two[63:0].
// Output stream m_*: result items. tuser holds item_kind; tdata holds,
// from bit 0: row_pc_start, row_reg_index, rule_kind, rule_reg,
// rule_offset, error_code, sig_frame, exotic_regs, fde_pc_end,
// return_register; tlast marks the final item of an input.
// cfg_load_bias is written whenever cfg_we is high.
// Sequence: an opcode is accepted in idle, then executed in the decode
// state. after_cie and start_fde then sweep all NUM_REGS CIE entries;
// remember and restore_state move NUM_REGS entries through the one-port
// stack memory. An fde info or error item is loaded into the output
// register from the decode state; a row emission gives NUM_REGS+1 items
// from the row state, one per cycle while the receiver does not stall.
// Reset clears all rule state and the stack count; the stack memory
// itself is not cleared. A stalled receiver holds the output register and
// the controller waits; no input is taken until the current one is done.
`default_nettype none
module cfi_row_table_builder
    import crtb_pkg::*;
#(
    parameter int NUM_REGS    = 17,
    parameter int STACK_DEPTH = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [63:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [143:0] s_tdata,   // reg_number, value, value_two
    input  wire logic [4:0]   s_tuser,   // opcode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [223:0]      m_tdata,   // see header for field order
    output logic [1:0]        m_tuser,   // item_kind
    output logic              m_tlast
);
    logic [63:0] bias_reg;
    crtb_cmd_t   cmd;
    crtb_stat_t  stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) bias_reg <= '0;
        else if (cfg_we) bias_reg <= cfg_wdata;
    end

    crtb_ctrl #(.NUM_REGS(NUM_REGS)) u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .stat, .cmd
    );

    crtb_dp #(.NUM_REGS(NUM_REGS), .STACK_DEPTH(STACK_DEPTH)) u_dp (
        .aclk, .aresetn,
        .cfg_load_bias (bias_reg),
        .in_opcode     (s_tuser),
        .in_reg_number (s_tdata[15:0]),
        .in_value      (s_tdata[79:16]),
        .in_value_two  (s_tdata[143:80]),
        .cmd, .stat,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
    );
endmodule
`default_nettype wire
